>>> rtl/pli_pkg.sv
package pli_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] entry_value;
        logic                     last;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

endpackage

>>> rtl/pli_cell.sv
module pli_cell
    import pli_pkg::*;
#(
    parameter int AW  = 4,
    parameter int IDX = 0
)
(
    input  logic                     clk,
    input  cell_op_t                 op,
    input  logic [AW-1:0]            sel,
    input  logic signed [DATA_W-1:0] ins_value,
    input  logic signed [DATA_W-1:0] prev_value,
    input  logic signed [DATA_W-1:0] next_value,
    input  logic signed [DATA_W-1:0] head_value,
    output logic signed [DATA_W-1:0] value
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // insert: the selected cell loads, cells behind it take from the front
    // rotate: cells up to the tail take from behind, the tail takes the head
    always_comb
    begin
        value_next = value_reg;
        case (op)
            CELL_INSERT:
            begin
                if (MY_IDX == sel)
                    value_next = ins_value;
                else if (MY_IDX > sel)
                    value_next = prev_value;
            end
            CELL_ROTATE:
            begin
                if (MY_IDX == sel)
                    value_next = head_value;
                else if (MY_IDX < sel)
                    value_next = next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/positional_insert_list.sv
// Ordered list of up to DEPTH signed values held in a chain of cells.
// An insert transaction leaves busy low, so inserts may be issued on
// consecutive cycles, and the status result is strobed on rsp_valid in the
// following cycle. A read-out transaction holds busy high while the chain
// steps the stored entries out of the head cell in order, because it
// rotates by one cell per cycle and the head cell is sent out each time; it
// ends with the list back in its original order. An empty read-out leaves
// busy low and yields one empty-status result. Each result is valid for
// exactly one cycle, in the cycle after the chain step that produced it;
// the receiver must take it then.
module positional_insert_list
    import pli_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output rsp_t rsp,
    output logic rsp_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    rsp_t          rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    cell_op_t      cell_op;
    logic [AW-1:0] cell_sel;
    logic          accept;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] cnt_ext;
    logic          range_bad;
    logic [AW-1:0] slot;
    logic [AW-1:0] tail;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic signed [DATA_W-1:0] head;

    assign busy      = (state_reg == S_READ);
    assign accept    = start && !busy;
    assign pos_ext   = PW'(cmd.position);
    assign cnt_ext   = PW'(count_reg);
    assign range_bad = (cmd.position == '0) || (pos_ext > cnt_ext + PW'(1));
    assign slot      = AW'(pos_ext - PW'(1));
    assign tail      = AW'(count_reg - CW'(1));
    assign head      = cell_value[0];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] prev_v;
            logic signed [DATA_W-1:0] next_v;
            if (i == 0)
            begin : g_first
                assign prev_v = cmd.value;
            end
            else
            begin : g_mid_prev
                assign prev_v = cell_value[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_tail
                assign next_v = head;
            end
            else
            begin : g_mid_next
                assign next_v = cell_value[i+1];
            end
            pli_cell #(
                .AW  (AW),
                .IDX (i)
            ) u_cell (
                .clk        (clk),
                .op         (cell_op),
                .sel        (cell_sel),
                .ins_value  (cmd.value),
                .prev_value (prev_v),
                .next_value (next_v),
                .head_value (head),
                .value      (cell_value[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        rsp_next       = '0;
        rsp_valid_next = 1'b0;
        cell_op        = CELL_HOLD;
        cell_sel       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_next.last = 1'b1;
                    if (cmd.func == FUNC_READ)
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next.status = ST_EMPTY;
                            rsp_valid_next  = 1'b1;
                        end
                        else
                        begin
                            state_next  = S_READ;
                            remain_next = count_reg;
                        end
                    end
                    else if (range_bad)
                    begin
                        rsp_next.status = ST_RANGE;
                        rsp_valid_next  = 1'b1;
                    end
                    else if (count_reg == FULL_COUNT)
                    begin
                        rsp_next.status = ST_FULL;
                        rsp_valid_next  = 1'b1;
                    end
                    else
                    begin
                        cell_op         = CELL_INSERT;
                        cell_sel        = slot;
                        count_next      = count_reg + CW'(1);
                        rsp_next.status = ST_INSERTED;
                        rsp_valid_next  = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cell_op              = CELL_ROTATE;
                cell_sel             = tail;
                rsp_next.status      = ST_ENTRY;
                rsp_next.entry_value = head;
                rsp_next.last        = (remain_reg == CW'(1));
                rsp_valid_next       = 1'b1;
                remain_next          = remain_reg - CW'(1);
                if (remain_reg == CW'(1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_read_remain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> remain_reg != '0 && remain_reg <= count_reg)
        else $error("read-out counter out of range");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.func == FUNC_INSERT && !range_bad && count_reg != FULL_COUNT
        |=> count_reg == $past(count_reg) + CW'(1) && rsp_valid
            && rsp.status == ST_INSERTED)
        else $error("insert did not grow the list");

    a_last_entry_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_ENTRY && rsp.last |-> !busy)
        else $error("final entry sent while still reading");

    a_mid_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_ENTRY && !rsp.last |-> busy)
        else $error("read-out ended early");

endmodule

>>> sim/tb_positional_insert_list.sv
`timescale 1ns / 100ps

module tb_positional_insert_list;
    import pli_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int NUM_RANDOM  = 118;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int CMD_W       = $bits(cmd_t);

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    rsp_t rsp;
    logic rsp_valid;

    positional_insert_list #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .rsp(rsp),
        .rsp_valid(rsp_valid)
    );

    cmd_t cmd_q[$];
    rsp_t list_results_q[$];

    logic signed [DATA_W-1:0] shadow_list[LIST_DEPTH];
    int shadow_len;
    int gen_len;

    bit taken;
    int idle_left;
    int cycle_cnt;
    int err_cnt;
    int rsp_cnt;
    int n_inserted;
    int n_range;
    int n_full;
    int n_reads;
    int n_entries_read;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic rsp_t make_rsp(logic [STAT_W-1:0] st, logic signed [DATA_W-1:0] v,
                                      logic lst);
        rsp_t r;
        r.status      = st;
        r.entry_value = v;
        r.last        = lst;
        return r;
    endfunction

    task automatic model_list_op(input cmd_t c);
        int slot;
        if (c.func == FUNC_READ)
        begin
            n_reads++;
            if (shadow_len == 0)
                list_results_q.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
            else
            begin
                for (int i = 0; i < shadow_len; i++)
                    list_results_q.push_back(make_rsp(ST_ENTRY, shadow_list[i],
                                                      (i == shadow_len - 1)));
                n_entries_read += shadow_len;
            end
        end
        else if (c.position == 0 || int'(c.position) > shadow_len + 1)
        begin
            n_range++;
            list_results_q.push_back(make_rsp(ST_RANGE, '0, 1'b1));
        end
        else if (shadow_len >= LIST_DEPTH)
        begin
            n_full++;
            list_results_q.push_back(make_rsp(ST_FULL, '0, 1'b1));
        end
        else
        begin
            slot = int'(c.position) - 1;
            for (int i = shadow_len; i > slot; i--)
                shadow_list[i] = shadow_list[i-1];
            shadow_list[slot] = c.value;
            shadow_len++;
            n_inserted++;
            list_results_q.push_back(make_rsp(ST_INSERTED, '0, 1'b1));
        end
    endtask

    // Queue a transaction and track the list length the stimulus expects.
    task automatic queue_cmd(input logic f, input logic [DATA_W-1:0] v, input int p);
        cmd_t c;
        c.func     = f;
        c.value    = v;
        c.position = p[POS_W-1:0];
        cmd_q.push_back(c);
        if (f == FUNC_INSERT && p >= 1 && p <= gen_len + 1 && gen_len < LIST_DEPTH)
            gen_len++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11)
            return 0;
        else if (r < 17)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Stimulus
    initial
    begin
        int r;
        int p;
        gen_len = 0;

        queue_cmd(FUNC_READ, $urandom, $urandom_range(0, 31));
        queue_cmd(FUNC_INSERT, 32'hFFFF_FFFF, 0);
        queue_cmd(FUNC_INSERT, 32'h1234_5678, 2);
        queue_cmd(FUNC_INSERT, 32'hAAAA_5555, 31);
        queue_cmd(FUNC_INSERT, 32'h7FFF_FFFF, 1);
        queue_cmd(FUNC_INSERT, 32'h8000_0000, 1);
        queue_cmd(FUNC_INSERT, 32'h0000_0000, 3);
        queue_cmd(FUNC_INSERT, 32'd12345, 2);
        queue_cmd(FUNC_INSERT, 32'h5555_AAAA, 6);
        queue_cmd(FUNC_INSERT, 32'hFFFF_FFFE, 5);
        queue_cmd(FUNC_READ, 32'h0, 0);
        queue_cmd(FUNC_READ, 32'hFFFF_FFFF, 31);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            r = $urandom_range(0, 99);
            if (gen_len < LIST_DEPTH)
            begin
                if (r < 10)
                    queue_cmd(FUNC_READ, $urandom, $urandom_range(0, 31));
                else if (r < 25)
                begin
                    p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(gen_len + 2, 31);
                    queue_cmd(FUNC_INSERT, $urandom, p);
                end
                else
                    queue_cmd(FUNC_INSERT, $urandom, $urandom_range(1, gen_len + 1));
            end
            else
            begin
                if (r < 30)
                    queue_cmd(FUNC_READ, $urandom, $urandom_range(0, 31));
                else if (r < 70)
                    queue_cmd(FUNC_INSERT, $urandom, $urandom_range(1, gen_len + 1));
                else
                begin
                    p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(gen_len + 2, 31);
                    queue_cmd(FUNC_INSERT, $urandom, p);
                end
            end
        end
    end

    // Reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_q.size() != 0 || start || list_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Run covered %0d inserts, %0d out-of-range, %0d full rejects, %0d read-outs",
                 n_inserted, n_range, n_full, n_reads);
        $display("%0d list entries read back, %0d results checked, %0d errors",
                 n_entries_read, rsp_cnt, err_cnt);
        if (err_cnt == 0 && list_results_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Driver
    always @(negedge clk or negedge rst_n)
    begin : driver
        logic nxt_start;
        cmd_t nxt_cmd;
        if (!rst_n)
        begin
            start     <= 1'b0;
            cmd       <= '0;
            taken     = 1'b0;
            idle_left = 0;
        end
        else
        begin
            nxt_start = start;
            nxt_cmd   = cmd;
            if (!start || taken)
            begin
                taken     = 1'b0;
                nxt_start = 1'b0;
                nxt_cmd   = CMD_W'({$urandom, $urandom});
                if (idle_left > 0)
                    idle_left--;
                else if (cmd_q.size() > 0)
                begin
                    nxt_cmd   = cmd_q.pop_front();
                    nxt_start = 1'b1;
                    idle_left = pick_gap();
                end
            end
            start <= nxt_start;
            cmd   <= nxt_cmd;
        end
    end

    // Accepted transactions feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            taken = 1'b1;
            model_list_op(cmd);
        end
    end

    // Monitor
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n && rsp_valid)
        begin
            rsp_cnt++;
            if (list_results_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected result status=%0d value=%0d last=%0b",
                         $time, rsp.status, rsp.entry_value, rsp.last);
            end
            else
            begin
                want = list_results_q.pop_front();
                if (rsp.status !== want.status)
                begin
                    err_cnt++;
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, rsp.status);
                end
                if (rsp.entry_value !== want.entry_value)
                begin
                    err_cnt++;
                    $display("%0t: entry_value mismatch expected %0d actual %0d",
                             $time, want.entry_value, rsp.entry_value);
                end
                if (rsp.last !== want.last)
                begin
                    err_cnt++;
                    $display("%0t: last mismatch expected %0b actual %0b",
                             $time, want.last, rsp.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        cycle_cnt      = 0;
        err_cnt        = 0;
        rsp_cnt        = 0;
        shadow_len     = 0;
        n_inserted     = 0;
        n_range        = 0;
        n_full         = 0;
        n_reads        = 0;
        n_entries_read = 0;
        for (int i = 0; i < LIST_DEPTH; i++)
            shadow_list[i] = '0;
    end

endmodule
